[hw/rtl/qph_pkg.sv]
// Shared types and codes for the quadratic-probing hash table.
// Used by qph_slot_store and quadratic_probe_hash_table_core; no dependencies.
package qph_pkg;

  // Fixed field widths of the request and response channels.
  localparam int ACT_W      = 2;
  localparam int KEY_PORT_W = 64;
  localparam int LEN_W      = 4;
  localparam int VAL_W      = 32;
  localparam int STATUS_W   = 2;
  localparam int IDX_W      = 10;
  localparam int CNT_W      = 11;

  // Defaults for the top-level parameters.
  localparam int TABLE_SLOTS_DEF   = 1021;
  localparam int KEY_CHARS_MAX_DEF = 8;

  // Polynomial hash multiplier.
  localparam int HASH_MULT = 31;

  typedef logic [ACT_W-1:0]    act_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [1:0]          slot_state_t;

  localparam act_t ACT_INSERT = 2'd0;
  localparam act_t ACT_SEARCH = 2'd1;
  localparam act_t ACT_REMOVE = 2'd2;

  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_NOT_FOUND = 2'd1;
  localparam status_t STATUS_DUPLICATE = 2'd2;
  localparam status_t STATUS_FULL      = 2'd3;

  // Per-slot occupancy: bit 0 is "used", bit 1 is "tombstone".
  localparam slot_state_t SLOT_FREE = 2'b00;
  localparam slot_state_t SLOT_LIVE = 2'b01;
  localparam slot_state_t SLOT_TOMB = 2'b10;

  // Control from the probe sequencer to the slot store.
  typedef struct packed {
    logic rd;
    logic wr_entry;
    logic wr_state;
  } qph_mem_ctl_t;

endpackage

[hw/rtl/qph_slot_store.sv]
// Slot storage: key/length/value memory and the occupancy memory.
// The occupancy memory is swept to free after reset. Depends on qph_pkg.
module qph_slot_store import qph_pkg::*; #(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int KEY_W       = 8 * KEY_CHARS_MAX_DEF,
  localparam int SLOT_W     = $clog2(TABLE_SLOTS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  qph_mem_ctl_t      ctl,
  input  logic [SLOT_W-1:0] addr,
  input  logic [KEY_W-1:0]  wr_key,
  input  logic [LEN_W-1:0]  wr_len,
  input  logic [VAL_W-1:0]  wr_val,
  input  slot_state_t       wr_state,
  output logic [KEY_W-1:0]  rd_key,
  output logic [LEN_W-1:0]  rd_len,
  output logic [VAL_W-1:0]  rd_val,
  output slot_state_t       rd_state,
  output logic              clr_busy
);

  localparam int ENT_W = KEY_W + LEN_W + VAL_W;

  logic [ENT_W-1:0]  ent_mem [TABLE_SLOTS];
  slot_state_t       st_mem  [TABLE_SLOTS];
  logic [ENT_W-1:0]  ent_rd_r;
  slot_state_t       st_rd_r;
  logic              clr_busy_r, clr_busy_nxt;
  logic [SLOT_W-1:0] clr_addr_r, clr_addr_nxt;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + SLOT_W'(1);
      if (clr_addr_r == SLOT_W'(TABLE_SLOTS - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_entry) begin
      ent_mem[addr] <= {wr_key, wr_len, wr_val};
    end
    if (ctl.rd) begin
      ent_rd_r <= ent_mem[addr];
    end
  end

  // The sequencer is held off while the sweep runs, so the two write sources never collide.
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      st_mem[clr_addr_r] <= SLOT_FREE;
    end else if (ctl.wr_state) begin
      st_mem[addr] <= wr_state;
    end
    if (ctl.rd) begin
      st_rd_r <= st_mem[addr];
    end
  end

  assign rd_key   = ent_rd_r[ENT_W-1 -: KEY_W];
  assign rd_len   = ent_rd_r[VAL_W +: LEN_W];
  assign rd_val   = ent_rd_r[VAL_W-1:0];
  assign rd_state = st_rd_r;
  assign clr_busy = clr_busy_r;

endmodule

[hw/rtl/quadratic_probe_hash_table_core.sv]
// Open-addressing hash table with quadratic probing and tombstones.
// Top level: request sequencer, hash reduction and probe stepping. Depends on qph_pkg,
// qph_slot_store.
//
//   Channel | Ports                                               | Direction
//   --------+-----------------------------------------------------+----------
//   in      | in_valid/in_ready, action, key_chars, key_length,   | request
//           | value_in                                            |
//   out     | out_valid/out_ready, status, value_out, slot_index, | response
//           | live_count                                          |
//
// A request passes through accept (S_IDLE), the hash (S_HASH, one key character a cycle
// through the shared multiply-and-reduce step), then per probe the registered memory read
// (S_RD) and the slot check (S_CHK), and last the hand-off of the result to the output register (S_EMIT).
// An unknown action skips the hash and the probes and goes straight to the hand-off.
// After reset the occupancy memory is swept to free, with in_ready low.
// One request is in work at a time; a new one is taken while the last result still waits
// in the output register, and the sequencer stalls only when a second result is ready.
module quadratic_probe_hash_table_core import qph_pkg::*; #(
  parameter int TABLE_SLOTS   = TABLE_SLOTS_DEF,
  parameter int KEY_CHARS_MAX = KEY_CHARS_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ACT_W-1:0]      in_action,
  input  logic [KEY_PORT_W-1:0] in_key_chars,
  input  logic [LEN_W-1:0]      in_key_length,
  input  logic [VAL_W-1:0]      in_value_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   out_status,
  output logic [VAL_W-1:0]      out_value_out,
  output logic [IDX_W-1:0]      out_slot_index,
  output logic [IDX_W-1:0]      out_live_count
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int KEY_W  = 8 * KEY_CHARS_MAX;
  // r*31 + c with r < TABLE_SLOTS stays below 64*TABLE_SLOTS.
  localparam int RED_W  = SLOT_W + 6;
  localparam logic [RED_W-1:0]  T_RED  = RED_W'(TABLE_SLOTS);
  localparam logic [SLOT_W:0]   T_P    = (SLOT_W + 1)'(TABLE_SLOTS);
  localparam logic [SLOT_W-1:0] I_LAST = SLOT_W'(TABLE_SLOTS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HASH = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]        state_r, state_nxt;
  act_t              act_r, act_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [KEY_W-1:0]  hkey_r, hkey_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [SLOT_W-1:0] p_r, p_nxt;
  logic [SLOT_W-1:0] d_r, d_nxt;
  logic [SLOT_W-1:0] i_r, i_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [VAL_W-1:0]  res_value_r, res_value_nxt;
  logic [IDX_W-1:0]  res_idx_r, res_idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [VAL_W-1:0]  out_value_r, out_value_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic [IDX_W-1:0]  out_live_r, out_live_nxt;

  logic [LEN_W-1:0]  len_sat;
  logic [KEY_W-1:0]  key_masked;
  logic [RED_W-1:0]  red_v;
  logic [SLOT_W:0]   p_sum;
  logic [SLOT_W:0]   d_sum;
  logic [SLOT_W-1:0] p_step;
  logic [SLOT_W-1:0] d_step;
  logic              slot_match;
  logic              clr_busy;

  qph_mem_ctl_t      mem_ctl;
  slot_state_t       mem_wr_state;
  logic [KEY_W-1:0]  rd_key;
  logic [LEN_W-1:0]  rd_len;
  logic [VAL_W-1:0]  rd_val;
  slot_state_t       rd_state;

  qph_slot_store #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KEY_W       (KEY_W)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mem_ctl),
    .addr     (p_r),
    .wr_key   (key_r),
    .wr_len   (len_r),
    .wr_val   (val_r),
    .wr_state (mem_wr_state),
    .rd_key   (rd_key),
    .rd_len   (rd_len),
    .rd_val   (rd_val),
    .rd_state (rd_state),
    .clr_busy (clr_busy)
  );

  assign in_ready = (state_r == S_IDLE) && !clr_busy;

  // Length saturation and masking of bytes past the key length.
  always_comb begin
    len_sat = (in_key_length > LEN_W'(KEY_CHARS_MAX)) ? LEN_W'(KEY_CHARS_MAX) : in_key_length;
    for (int b = 0; b < KEY_CHARS_MAX; b++) begin
      key_masked[b*8 +: 8] = (LEN_W'(b) < len_sat) ? in_key_chars[b*8 +: 8] : 8'h00;
    end
  end

  // Shared hash step: (r * 31 + c) mod TABLE_SLOTS by six conditional subtractions.
  always_comb begin
    red_v = RED_W'(p_r) * RED_W'(HASH_MULT) + RED_W'(hkey_r[7:0]);
    for (int j = 5; j >= 0; j--) begin
      if (red_v >= (T_RED << j)) begin
        red_v = red_v - (T_RED << j);
      end
    end
  end

  // Probe stepping: slot(i+1) = slot(i) + (2i+1), increments kept reduced.
  always_comb begin
    p_sum  = {1'b0, p_r} + {1'b0, d_r};
    d_sum  = {1'b0, d_r} + (SLOT_W + 1)'(2);
    p_step = (p_sum >= T_P) ? SLOT_W'(p_sum - T_P) : p_sum[SLOT_W-1:0];
    d_step = (d_sum >= T_P) ? SLOT_W'(d_sum - T_P) : d_sum[SLOT_W-1:0];
  end

  assign slot_match = (rd_state == SLOT_LIVE) && (rd_len == len_r) && (rd_key == key_r);

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    len_nxt        = len_r;
    key_nxt        = key_r;
    hkey_nxt       = hkey_r;
    val_nxt        = val_r;
    rem_nxt        = rem_r;
    p_nxt          = p_r;
    d_nxt          = d_r;
    i_nxt          = i_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    res_idx_nxt    = res_idx_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_idx_nxt    = out_idx_r;
    out_live_nxt   = out_live_r;
    mem_ctl        = '0;
    mem_wr_state   = SLOT_LIVE;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          act_nxt        = in_action;
          len_nxt        = len_sat;
          key_nxt        = key_masked;
          hkey_nxt       = key_masked;
          val_nxt        = in_value_in;
          rem_nxt        = len_sat;
          p_nxt          = '0;
          d_nxt          = SLOT_W'(1);
          i_nxt          = '0;
          res_status_nxt = (in_action == ACT_INSERT) ? STATUS_FULL : STATUS_NOT_FOUND;
          res_value_nxt  = '0;
          res_idx_nxt    = '0;
          if (in_action != ACT_INSERT && in_action != ACT_SEARCH &&
              in_action != ACT_REMOVE) begin
            state_nxt = S_EMIT;
          end else if (len_sat == '0) begin
            state_nxt = S_RD;
          end else begin
            state_nxt = S_HASH;
          end
        end
      end

      S_HASH: begin
        p_nxt    = red_v[SLOT_W-1:0];
        hkey_nxt = hkey_r >> 8;
        rem_nxt  = rem_r - LEN_W'(1);
        if (rem_r == LEN_W'(1)) begin
          state_nxt = S_RD;
        end
      end

      S_RD: begin
        mem_ctl.rd = 1'b1;
        state_nxt  = S_CHK;
      end

      S_CHK: begin
        // Default: move on to the next probe unless an arm below ends the walk.
        p_nxt     = p_step;
        d_nxt     = d_step;
        i_nxt     = i_r + SLOT_W'(1);
        state_nxt = (i_r == I_LAST) ? S_EMIT : S_RD;
        case (act_r) inside
          ACT_INSERT: begin
            if (rd_state[0] == 1'b0 || rd_state[1] == 1'b1) begin
              mem_ctl.wr_entry = 1'b1;
              mem_ctl.wr_state = 1'b1;
              mem_wr_state     = SLOT_LIVE;
              cnt_nxt          = cnt_r + CNT_W'(1);
              res_status_nxt   = STATUS_OK;
              res_idx_nxt      = IDX_W'({{IDX_W{1'b0}}, p_r});
              p_nxt            = p_r;
              state_nxt        = S_EMIT;
            end else if (slot_match) begin
              res_status_nxt = STATUS_DUPLICATE;
              res_idx_nxt    = IDX_W'({{IDX_W{1'b0}}, p_r});
              p_nxt          = p_r;
              state_nxt      = S_EMIT;
            end
          end
          ACT_SEARCH, ACT_REMOVE: begin
            if (rd_state == SLOT_FREE) begin
              p_nxt     = p_r;
              state_nxt = S_EMIT;
            end else if (slot_match) begin
              res_status_nxt = STATUS_OK;
              res_idx_nxt    = IDX_W'({{IDX_W{1'b0}}, p_r});
              if (act_r == ACT_SEARCH) begin
                res_value_nxt = rd_val;
              end else begin
                mem_ctl.wr_state = 1'b1;
                mem_wr_state     = SLOT_TOMB;
                cnt_nxt          = cnt_r - CNT_W'(1);
              end
              p_nxt     = p_r;
              state_nxt = S_EMIT;
            end
          end
          default: begin
            state_nxt = S_EMIT;
          end
        endcase
      end

      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          out_idx_nxt    = res_idx_r;
          out_live_nxt   = cnt_r[IDX_W-1:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    len_r        <= len_nxt;
    key_r        <= key_nxt;
    hkey_r       <= hkey_nxt;
    val_r        <= val_nxt;
    rem_r        <= rem_nxt;
    p_r          <= p_nxt;
    d_r          <= d_nxt;
    i_r          <= i_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    res_idx_r    <= res_idx_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_idx_r    <= out_idx_nxt;
    out_live_r   <= out_live_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_value_out  = out_value_r;
  assign out_slot_index = out_idx_r;
  assign out_live_count = out_live_r;

endmodule
